// ===== sv/rotation_matrix_to_euler_top_defines.svh =====
// Assertion helpers for the rotation matrix to Euler angle block.
`ifndef ROTATION_MATRIX_TO_EULER_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define RME_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rme assertion failed");
// Check a property at every edge, reset included.
`define RME_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rme assertion failed");
`else
`define RME_ASSERT(label, clk, rst_n, prop)
`define RME_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/rme_pkg.sv =====
`default_nettype none
package rme_pkg;

    localparam int ANG_W      = 25;   // internal angle, 2^-20 rad
    localparam int Q12_W      = ANG_W - 8;
    localparam int DW         = 36;   // CORDIC vector width
    localparam int OPW        = 17;   // CORDIC operand width
    localparam int ISQ_STAGES = 15;
    localparam int TAB_LEN    = 24;

    localparam logic signed [ANG_W-1:0] PI_Q20      = 25'sd3294199;
    localparam logic signed [15:0]      HALF_PI_Q12 = 16'sd6434;
    localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_NEG  = 2'd1,
        LOCK_POS  = 2'd2
    } lock_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m10;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m22;
        logic signed [15:0] s;
        lock_t              lock;
    } item_t;

    function automatic logic signed [ANG_W-1:0] atan_tab(input int i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            0:  v = 25'sd823550;
            1:  v = 25'sd486170;
            2:  v = 25'sd256879;
            3:  v = 25'sd130396;
            4:  v = 25'sd65451;
            5:  v = 25'sd32757;
            6:  v = 25'sd16383;
            7:  v = 25'sd8192;
            8:  v = 25'sd4096;
            9:  v = 25'sd2048;
            10: v = 25'sd1024;
            11: v = 25'sd512;
            12: v = 25'sd256;
            13: v = 25'sd128;
            14: v = 25'sd64;
            15: v = 25'sd32;
            16: v = 25'sd16;
            17: v = 25'sd8;
            18: v = 25'sd4;
            19: v = 25'sd2;
            20: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round to Q4.12 with floor((v + 128) / 256).
    function automatic logic signed [Q12_W-1:0] to_q12(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] t;
        t = v + 25'sd128;
        return t[ANG_W-1:8];
    endfunction

endpackage
`default_nettype wire

// ===== sv/rotation_matrix_to_euler_top.sv =====
`default_nettype none
`include "rotation_matrix_to_euler_top_defines.svh"
// Rotation matrix to Euler angles.
// s_ channel: one request carries seven Q2.14 matrix elements in s_tdata,
//   from the lowest bit up m00, m01, m02, m10, m12, m20, m22.
// m_ channel: angle_x, angle_y, angle_z in Q4.12 radians in m_tdata and the
//   gimbal-lock case in m_tuser (0 normal, 1 lock at -1, 2 lock at +1).
// cfg_we / cfg_wdata write lock_epsilon (reset value 16); write while idle.
// Throughput: one matrix per cycle while the output is not stalled. The pipeline
//   is made of the input and square stages, a 15-stage square root, the
//   CORDIC of CORDIC_STAGES + 1 stages, rounding and the output register.
//   All five atan2 units run side by side.
// Reset empties the pipeline and restores lock_epsilon.
// When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
module rotation_matrix_to_euler_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [14:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,   // m00, m01, m02, m10, m12, m20, m22
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // angle_x, angle_y, angle_z
    output logic [1:0]        m_tuser    // lock_case
);
    localparam int ISQ = rme_pkg::ISQ_STAGES;
    localparam int CL  = CORDIC_STAGES + 1;
    localparam int AW  = rme_pkg::ANG_W;
    localparam int QW  = rme_pkg::Q12_W;
    localparam int OPW = rme_pkg::OPW;

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic [14:0] eps_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) eps_reg <= 15'd16;
        else if (cfg_we) eps_reg <= cfg_wdata;
    end

    // Stage A: lock test and clamp.
    logic signed [15:0] m02_in;
    logic signed [16:0] dn, dp;
    logic [16:0] an, ap;
    rme_pkg::item_t item_in;
    always_comb begin
        m02_in = s_tdata[47:32];
        dn = 17'(m02_in) + 17'sd16384;
        dp = 17'(m02_in) - 17'sd16384;
        an = dn[16] ? 17'(-dn) : 17'(dn);
        ap = dp[16] ? 17'(-dp) : 17'(dp);
        item_in.m00 = s_tdata[15:0];
        item_in.m01 = s_tdata[31:16];
        item_in.m10 = s_tdata[63:48];
        item_in.m12 = s_tdata[79:64];
        item_in.m20 = s_tdata[95:80];
        item_in.m22 = s_tdata[111:96];
        if (m02_in > rme_pkg::ONE_Q14) item_in.s = rme_pkg::ONE_Q14;
        else if (m02_in < -rme_pkg::ONE_Q14) item_in.s = -rme_pkg::ONE_Q14;
        else item_in.s = m02_in;
        priority if (an < {2'b0, eps_reg}) item_in.lock = rme_pkg::LOCK_NEG;
        else if (ap < {2'b0, eps_reg}) item_in.lock = rme_pkg::LOCK_POS;
        else item_in.lock = rme_pkg::LOCK_NONE;
    end

    rme_pkg::item_t item_a_reg, item_b_reg;
    logic valid_a_reg, valid_b_reg;
    logic [28:0] v_b_reg;
    logic signed [31:0] sq;
    assign sq = item_a_reg.s * item_a_reg.s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (ce) begin
            valid_a_reg <= s_tvalid;
            valid_b_reg <= valid_a_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (ce) begin
            item_a_reg <= item_in;
            item_b_reg <= item_a_reg;
            v_b_reg    <= 29'(32'sd268435456 - sq);
        end
    end

    logic [14:0] root;
    rme_isqrt u_isqrt (.aclk(aclk), .en(ce), .v_in(v_b_reg), .root(root));

    // Hold the operands alongside the square root.
    rme_pkg::item_t item_d_reg [0:ISQ-1];
    logic           valid_d_reg [0:ISQ-1];
    always_ff @(posedge aclk) begin
        if (ce) begin
            item_d_reg[0] <= item_b_reg;
            for (int k = 1; k < ISQ; k++) item_d_reg[k] <= item_d_reg[k-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ISQ; k++) valid_d_reg[k] <= 1'b0;
        end else if (ce) begin
            valid_d_reg[0] <= valid_b_reg;
            for (int k = 1; k < ISQ; k++) valid_d_reg[k] <= valid_d_reg[k-1];
        end
    end

    rme_pkg::item_t it;
    assign it = item_d_reg[ISQ-1];

    logic signed [OPW-1:0] ys [0:4];
    logic signed [OPW-1:0] xs [0:4];
    always_comb begin
        ys[0] = OPW'(it.s);
        xs[0] = OPW'({1'b0, root});
        ys[1] = OPW'(it.m12);
        xs[1] = OPW'(it.m22);
        ys[2] = -OPW'(it.m12);
        xs[2] = -OPW'(it.m22);
        ys[3] = -OPW'(it.m01);
        xs[3] = -OPW'(it.m00);
        // Share the first-solution z unit with the lock case.
        unique case (it.lock)
            rme_pkg::LOCK_NEG: begin
                ys[4] = OPW'(it.m10);
                xs[4] = OPW'(it.m20);
            end
            rme_pkg::LOCK_POS: begin
                ys[4] = -OPW'(it.m10);
                xs[4] = -OPW'(it.m20);
            end
            default: begin
                ys[4] = OPW'(it.m01);
                xs[4] = OPW'(it.m00);
            end
        endcase
    end

    logic signed [AW-1:0] zc [0:4];
    for (genvar u = 0; u < 5; u++) begin : g_cordic
        rme_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
            .aclk(aclk), .en(ce), .y_in(ys[u]), .x_in(xs[u]), .z_out(zc[u])
        );
    end

    rme_pkg::lock_t lock_c_reg [0:CL-1];
    logic           valid_c_reg [0:CL-1];
    always_ff @(posedge aclk) begin
        if (ce) begin
            lock_c_reg[0] <= it.lock;
            for (int k = 1; k < CL; k++) lock_c_reg[k] <= lock_c_reg[k-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CL; k++) valid_c_reg[k] <= 1'b0;
        end else if (ce) begin
            valid_c_reg[0] <= valid_d_reg[ISQ-1];
            for (int k = 1; k < CL; k++) valid_c_reg[k] <= valid_c_reg[k-1];
        end
    end

    // Stage R: round both solutions.
    logic signed [QW-1:0] x1_r_reg, x2_r_reg, y1_r_reg, y2_r_reg, z1_r_reg, z2_r_reg;
    rme_pkg::lock_t lock_r_reg;
    logic valid_r_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            x1_r_reg   <= rme_pkg::to_q12(-zc[0]);
            x2_r_reg   <= rme_pkg::to_q12(rme_pkg::PI_Q20 + zc[0]);
            y1_r_reg   <= rme_pkg::to_q12(zc[1]);
            y2_r_reg   <= rme_pkg::to_q12(zc[2]);
            z2_r_reg   <= rme_pkg::to_q12(zc[3]);
            z1_r_reg   <= rme_pkg::to_q12(zc[4]);
            lock_r_reg <= lock_c_reg[CL-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) valid_r_reg <= 1'b0;
        else if (ce) valid_r_reg <= valid_c_reg[CL-1];
    end

    function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    logic [QW+1:0] sum1, sum2;
    logic signed [15:0] ax_next, ay_next, az_next;
    always_comb begin
        sum1 = (QW+2)'(mag(x1_r_reg)) + (QW+2)'(mag(y1_r_reg)) + (QW+2)'(mag(z1_r_reg));
        sum2 = (QW+2)'(mag(x2_r_reg)) + (QW+2)'(mag(y2_r_reg)) + (QW+2)'(mag(z2_r_reg));
        unique case (lock_r_reg)
            rme_pkg::LOCK_NEG: begin
                ax_next = '0;
                ay_next = rme_pkg::HALF_PI_Q12;
                az_next = z1_r_reg[15:0];
            end
            rme_pkg::LOCK_POS: begin
                ax_next = '0;
                ay_next = -rme_pkg::HALF_PI_Q12;
                az_next = z1_r_reg[15:0];
            end
            default: begin
                if (sum1 <= sum2) begin
                    ax_next = x1_r_reg[15:0];
                    ay_next = y1_r_reg[15:0];
                    az_next = z1_r_reg[15:0];
                end else begin
                    ax_next = x2_r_reg[15:0];
                    ay_next = y2_r_reg[15:0];
                    az_next = z2_r_reg[15:0];
                end
            end
        endcase
    end

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [1:0] lock_reg;
    logic m_tvalid_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_reg   <= az_next;
            lock_reg <= lock_r_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (ce) m_tvalid_reg <= valid_r_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {az_reg, ay_reg, ax_reg};
    assign m_tuser  = lock_reg;

    `RME_ASSERT(a_lock_x_zero, aclk, aresetn, (m_tvalid && m_tuser != rme_pkg::LOCK_NONE) |-> (m_tdata[15:0] == 16'd0))
    `RME_ASSERT(a_lock_neg_y, aclk, aresetn, (m_tvalid && m_tuser == rme_pkg::LOCK_NEG) |-> (m_tdata[31:16] == rme_pkg::HALF_PI_Q12))
    `RME_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
endmodule
`default_nettype wire

// ===== sv/rme_isqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module rme_isqrt (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [28:0] v_in,
    output logic      [14:0] root
);
    localparam int N = rme_pkg::ISQ_STAGES;

    logic [29:0] v_st [0:N];
    logic [29:0] r_st [0:N];

    assign v_st[0] = {1'b0, v_in};
    assign r_st[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [29:0] BIT = 30'(1) << (2 * (N - 1 - k));
        logic [29:0] trial;
        logic [29:0] v_reg, r_reg;
        assign trial = r_st[k] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (v_st[k] >= trial) begin
                    v_reg <= v_st[k] - trial;
                    r_reg <= (r_st[k] >> 1) + BIT;
                end else begin
                    v_reg <= v_st[k];
                    r_reg <= r_st[k] >> 1;
                end
            end
        end
        assign v_st[k+1] = v_reg;
        assign r_st[k+1] = r_reg;
    end

    assign root = r_st[N][14:0];
endmodule
`default_nettype wire

// ===== sv/rme_cordic.sv =====
`default_nettype none
// Pipelined vectoring CORDIC atan2 with an input register ahead of the rotation stages.
module rme_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic signed [rme_pkg::OPW-1:0]     y_in,
    input  wire logic signed [rme_pkg::OPW-1:0]     x_in,
    output logic signed      [rme_pkg::ANG_W-1:0]   z_out
);
    localparam int DW  = rme_pkg::DW;
    localparam int OPW = rme_pkg::OPW;
    localparam int AW  = rme_pkg::ANG_W;

    logic signed [DW-1:0] xs_st [0:STAGES];
    logic signed [DW-1:0] ys_st [0:STAGES];
    logic signed [AW-1:0] z_st  [0:STAGES];
    logic                 zero_st [0:STAGES];

    // Fold the left half plane onto the right one.
    logic signed [OPW-1:0] xf, yf;
    logic signed [AW-1:0]  z0;
    always_comb begin
        if (x_in < 0) begin
            xf = -x_in;
            yf = -y_in;
            z0 = (y_in >= 0) ? rme_pkg::PI_Q20 : -rme_pkg::PI_Q20;
        end else begin
            xf = x_in;
            yf = y_in;
            z0 = '0;
        end
    end

    logic signed [DW-1:0] xs0_reg, ys0_reg;
    logic signed [AW-1:0] z0_reg;
    logic                 zero0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xs0_reg   <= {{(DW-OPW-16){xf[OPW-1]}}, xf, 16'b0};
            ys0_reg   <= {{(DW-OPW-16){yf[OPW-1]}}, yf, 16'b0};
            z0_reg    <= z0;
            zero0_reg <= (x_in == 0) && (y_in == 0);
        end
    end
    assign xs_st[0]   = xs0_reg;
    assign ys_st[0]   = ys0_reg;
    assign z_st[0]    = z0_reg;
    assign zero_st[0] = zero0_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [AW-1:0] ANG = rme_pkg::atan_tab(i);
        logic signed [DW-1:0] dx, dy;
        logic signed [DW-1:0] xs_reg, ys_reg;
        logic signed [AW-1:0] z_reg;
        logic                 zero_reg;
        assign dx = ys_st[i] >>> i;
        assign dy = xs_st[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (ys_st[i] > 0) begin
                    xs_reg <= xs_st[i] + dx;
                    ys_reg <= ys_st[i] - dy;
                    z_reg  <= z_st[i] + ANG;
                end else begin
                    xs_reg <= xs_st[i] - dx;
                    ys_reg <= ys_st[i] + dy;
                    z_reg  <= z_st[i] - ANG;
                end
                zero_reg <= zero_st[i];
            end
        end
        assign xs_st[i+1]   = xs_reg;
        assign ys_st[i+1]   = ys_reg;
        assign z_st[i+1]    = z_reg;
        assign zero_st[i+1] = zero_reg;
    end

    assign z_out = zero_st[STAGES] ? '0 : z_st[STAGES];
endmodule
`default_nettype wire

// ===== test/tb_rotation_matrix_to_euler_top.sv =====
`default_nettype none
module tb_rotation_matrix_to_euler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 20;
    localparam longint PI_R  = 3294199;
    localparam longint HPI_R = 1647099;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        rme_pkg::lock_t     lock;
    } angles_t;

    typedef struct {
        logic [111:0] data;
        bit           has_exp;
        angles_t      exp;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [14:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;

    rotation_matrix_to_euler_top #(.CORDIC_STAGES(STAGES)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    angles_t  pending_angles[$];
    longint   epsilon = 16;
    int       mismatches = 0;
    bit       calm = 1'b0;      // no idling in the last part
    bit       hold_off = 1'b0;  // long receiver hold-off

    function automatic longint asr_l(longint v, int s);
        return (v >= 0) ? (v >>> s) : (-1 - ((-1 - v) >>> s));
    endfunction

    function automatic longint atan_tab_l(int i);
        longint t[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32,
                          16, 8, 4, 2, 1, 0, 0, 0};
        return t[i];
    endfunction

    function automatic longint cordic_atan2(longint y, longint x);
        longint z, xs, ys, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_R : -PI_R;
            x = -x;
            y = -y;
        end
        xs = x * 65536;
        ys = y * 65536;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = asr_l(ys, i);
            dy = asr_l(xs, i);
            if (ys > 0) begin
                xs += dx; ys -= dy; z += atan_tab_l(i);
            end else begin
                xs -= dx; ys += dy; z -= atan_tab_l(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_q12(longint v);
        return asr_l(v + 128, 8);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 30;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic angles_t predict_angles(logic [111:0] d);
        longint m00, m01, m02, m10, m12, m20, m22, s, c;
        longint x1, x2, y1, y2, z1, z2, ax, ay, az;
        angles_t r;
        m00 = longint'($signed(d[15:0]));
        m01 = longint'($signed(d[31:16]));
        m02 = longint'($signed(d[47:32]));
        m10 = longint'($signed(d[63:48]));
        m12 = longint'($signed(d[79:64]));
        m20 = longint'($signed(d[95:80]));
        m22 = longint'($signed(d[111:96]));
        if (absl(m02 + 16384) < epsilon) begin
            r.lock = rme_pkg::LOCK_NEG;
            ax = 0; ay = round_q12(HPI_R);
            az = round_q12(cordic_atan2(m10, m20));
        end else if (absl(m02 - 16384) < epsilon) begin
            r.lock = rme_pkg::LOCK_POS;
            ax = 0; ay = round_q12(-HPI_R);
            az = round_q12(cordic_atan2(-m10, -m20));
        end else begin
            s = m02;
            if (s > 16384) s = 16384;
            if (s < -16384) s = -16384;
            c = int_sqrt((64'sd1 << 28) - s * s);
            x1 = -cordic_atan2(s, c);
            x2 = round_q12(PI_R - x1);
            x1 = round_q12(x1);
            y1 = round_q12(cordic_atan2(m12, m22));
            z1 = round_q12(cordic_atan2(m01, m00));
            y2 = round_q12(cordic_atan2(-m12, -m22));
            z2 = round_q12(cordic_atan2(-m01, -m00));
            r.lock = rme_pkg::LOCK_NONE;
            if (absl(x1) + absl(y1) + absl(z1) <= absl(x2) + absl(y2) + absl(z2)) begin
                ax = x1; ay = y1; az = z1;
            end else begin
                ax = x2; ay = y2; az = z2;
            end
        end
        r.ax = ax[15:0];
        r.ay = ay[15:0];
        r.az = az[15:0];
        return r;
    endfunction

    function automatic logic [111:0] pack_matrix(int m00, int m01, int m02, int m10,
                                                 int m12, int m20, int m22);
        return {m22[15:0], m20[15:0], m12[15:0], m10[15:0], m02[15:0], m01[15:0],
                m00[15:0]};
    endfunction

    // Matrix with random elements; m02 is sometimes close to +1 or -1.
    function automatic logic [111:0] random_matrix();
        int m02;
        case ($urandom_range(0, 5))
            0: m02 = 16384 - $urandom_range(0, 40);
            1: m02 = -16384 + $urandom_range(0, 40);
            2: m02 = $urandom_range(0, 65535) - 32768;
            default: m02 = $urandom_range(0, 32768) - 16384;
        endcase
        if ($urandom_range(0, 9) == 0)
            return 112'({$urandom, $urandom, $urandom, $urandom});
        return pack_matrix($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                           m02, $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384);
    endfunction

    task automatic send_request(logic [111:0] d);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        pending_angles.push_back(predict_angles(d));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_and_write(logic [14:0] value);
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        epsilon    = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Receiver with random stalls and one long hold-off.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            if (!calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        angles_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], rme_pkg::lock_t'(m_tuser)};
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_angles.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d lock=%0d got x=%0d y=%0d z=%0d lock=%0d",
                                 want.ax, want.ay, want.az, want.lock,
                                 got.ax, got.ay, got.az, got.lock);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t r;
        logic [14:0] settings[5] = '{15'd0, 15'd16384, 15'd1, 15'd200, 15'd16};
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, identity, both locks, atan2(0,0), saturation
        r.has_exp = 1'b0;
        r.data = pack_matrix(0, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1'b1;
        r.exp = '{ax: 16'sd0, ay: 16'sd0, az: 16'sd0, lock: rme_pkg::LOCK_NONE};
        rows.push_back(r);
        r.has_exp = 1'b0;
        r.data = pack_matrix(16384, 0, 0, 0, 0, 0, 16384); rows.push_back(r);
        r.data = pack_matrix(0, 0, -16384, 0, 0, 16384, 0);
        r.has_exp = 1'b1;
        r.exp = '{ax: 16'sd0, ay: rme_pkg::HALF_PI_Q12, az: 16'sd0, lock: rme_pkg::LOCK_NEG};
        rows.push_back(r);
        r.data = pack_matrix(0, 0, 16384, 0, 0, 0, 0);
        r.exp = '{ax: 16'sd0, ay: -rme_pkg::HALF_PI_Q12, az: 16'sd0, lock: rme_pkg::LOCK_POS};
        rows.push_back(r);
        r.has_exp = 1'b0;
        r.data = pack_matrix(0, 0, -16370, 5000, 0, -9000, 0); rows.push_back(r);
        r.data = pack_matrix(0, 0, 16370, -5000, 0, 9000, 0); rows.push_back(r);
        r.data = pack_matrix(0, 0, -16368, 0, 0, 0, 0); rows.push_back(r);
        r.data = pack_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767); rows.push_back(r);
        r.data = pack_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        rows.push_back(r);
        r.data = pack_matrix(-16384, 0, 0, 0, 0, 0, -16384); rows.push_back(r);
        r.data = pack_matrix(0, 16384, 8192, 0, -16384, 0, 0); rows.push_back(r);
        r.data = pack_matrix(-1, 0, -8192, 0, 0, 0, -1); rows.push_back(r);
        r.data = pack_matrix(11585, -11585, 11585, 0, 11585, 0, -11585); rows.push_back(r);
        foreach (rows[i]) begin
            send_request(rows[i].data);
            if (rows[i].has_exp) pending_angles[pending_angles.size() - 1] = rows[i].exp;
        end

        // hold off the receiver while the sender keeps going
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++) send_request(random_matrix());

        foreach (settings[k]) begin
            drain_and_write(settings[k]);
            if (k == 0) begin
                send_request(pack_matrix(0, 0, 16384, 0, 0, 0, 0));
                send_request(pack_matrix(0, 0, -16384, 0, 0, 0, 0));
            end
            if (k == 1) send_request(pack_matrix(0, 0, 0, 7, 0, 9, 0));
            if (k == 4) calm = 1'b1;
            for (int i = 0; i < (k == 4 ? 250 : 240); i++) send_request(random_matrix());
            if (k == 3) calm = 1'b0;
        end
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== rotation_matrix_to_euler_top.f =====
+incdir+sv
sv/rme_pkg.sv
sv/rme_isqrt.sv
sv/rme_cordic.sv
sv/rotation_matrix_to_euler_top.sv
test/tb_rotation_matrix_to_euler_top.sv
